[hdl/multichannel_trimmed_mean_filter_macros.svh]
// Assertion macros shared by the filter RTL.
`ifndef MULTICHANNEL_TRIMMED_MEAN_FILTER_MACROS_SVH
`define MULTICHANNEL_TRIMMED_MEAN_FILTER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define MTMF_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define MTMF_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

[hdl/mtmf_pkg.sv]
// Package with the payload types and fixed constants of the trimmed-mean filter.
`timescale 1ns / 1ps
package mtmf_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int CHANNEL_W   = 3;

	typedef logic [SAMPLE_W-1:0]  sample_t;
	typedef logic [CHANNEL_W-1:0] channel_t;

endpackage

[hdl/mtmf_in_if.sv]
// Interface carrying incoming channel and sample beats.
`timescale 1ns / 1ps
interface mtmf_in_if import mtmf_pkg::*; ();

	logic     valid;
	logic     ready;
	channel_t channel;
	sample_t  sample;

	modport source (output valid, output channel, output sample, input ready);
	modport sink (input valid, input channel, input sample, output ready);

endinterface

[hdl/mtmf_out_if.sv]
// Interface carrying filtered result beats.
`timescale 1ns / 1ps
interface mtmf_out_if import mtmf_pkg::*; ();

	logic     valid;
	logic     ready;
	channel_t out_channel;
	sample_t  filtered;

	modport source (output valid, output out_channel, output filtered, input ready);
	modport sink (input valid, input out_channel, input filtered, output ready);

endinterface

[hdl/mtmf_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module mtmf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 40
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/multichannel_trimmed_mean_filter.sv]
// Top level of the multichannel trimmed-mean filter.
`timescale 1ns / 1ps
`include "multichannel_trimmed_mean_filter_macros.svh"
// Each beat on samples carries a channel number and a 16-bit unsigned distance. The
// sample replaces the oldest one in that channel's window of WINDOW samples, the window
// is sorted, KEPT sorted values starting at position WINDOW/2-OFFSET are summed (a
// position outside the window adds zero) and the truncated mean comes out on results
// with the channel number. Windows start as all zero. A channel at or above
// NUM_CHANNELS leaves every window alone and returns zero. The windows live in one
// RAM of NUM_CHANNELS*WINDOW words as rings with a write pointer per channel; a
// per-channel full flag makes slots that were never written read as zero, so no
// clearing pass is needed after reset. One item at a time is processed: the accept
// cycle writes the sample, the window is streamed out of the RAM port into an
// insertion sorter, the kept values are accumulated, the sum is multiplied by a
// fixed-point reciprocal of KEPT to form the quotient and the quotient is loaded
// into the output register once that is free. An out-of-range channel goes
// straight from the accept to the output register load. The result register lets
// the next beat be accepted while a result still waits; the block only stalls when
// a second result is ready before the first is taken.
module multichannel_trimmed_mean_filter import mtmf_pkg::*; #(
	parameter int NUM_CHANNELS = 5,
	parameter int WINDOW       = 8,
	parameter int KEPT         = 4,
	parameter int OFFSET       = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	mtmf_in_if.sink    samples,
	mtmf_out_if.source results
);

	localparam int DEPTH = NUM_CHANNELS * WINDOW;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int IW    = $clog2(WINDOW);
	localparam int RCW   = $clog2(WINDOW + 1);
	localparam int KCW   = $clog2(KEPT + 1);
	localparam int SW    = SAMPLE_W + $clog2(KEPT + 1);
	localparam int PW    = $clog2(WINDOW + KEPT + OFFSET + 1) + 1;
	localparam int START = (WINDOW / 2) - OFFSET;

	// Division by KEPT as a multiply by ceil(2^RSH / KEPT) and a right shift by RSH,
	// exact for every sum that fits in SW bits.
	localparam int     RSH   = SW + $clog2(KEPT);
	localparam int     MW    = SW + 1;
	localparam int     PRW   = SW + MW;
	localparam longint RECIP = ((longint'(1) << RSH) + longint'(KEPT) - 1) / longint'(KEPT);

	localparam logic signed [PW-1:0] START_S = PW'(START);
	localparam logic signed [PW-1:0] WIN_S   = PW'(WINDOW);
	localparam logic [MW-1:0]        RECIP_M = MW'(RECIP);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SUM,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t              state_q;
	logic [RCW-1:0]      rd_cnt_q;
	logic                ins_s1;
	logic                rd_ok_s1;
	logic [KCW-1:0]      kept_cnt_q;
	logic signed [PW-1:0] pos_q;
	logic [SW-1:0]       sum_q;
	sample_t             quo_q;
	channel_t            ch_q;
	logic [CW-1:0]       ch_idx_q;
	logic                out_valid_q;
	channel_t            out_channel_q;
	sample_t             filtered_q;
	logic [IW-1:0]       ptr_q [NUM_CHANNELS];
	logic                full_q [NUM_CHANNELS];
	sample_t             sorted_q [WINDOW];

	logic          accept;
	logic          ch_ok;
	logic [CW-1:0] in_idx;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	sample_t       ram_rdata;
	logic          rd_issue;
	logic          rd_ok;
	sample_t       ins_val;
	logic [WINDOW-1:0] le;
	sample_t       sort_nxt [WINDOW];
	logic          pos_in;
	logic          last_kept;
	logic [SW-1:0] sum_nxt;
	logic [PRW-1:0] prod;
	logic          out_free;

	// Input side: a new beat is taken only when the datapath is free.
	assign samples.ready = (state_q == ST_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign in_idx        = CW'(samples.channel);
	assign ch_ok         = 32'(samples.channel) < 32'(NUM_CHANNELS);

	// The new sample overwrites the oldest slot of its channel's ring.
	assign ram_we    = accept && ch_ok;
	assign ram_waddr = AW'(in_idx) * AW'(WINDOW) + AW'(ptr_q[in_idx]);

	// Window read-out; slots never written since reset stand for zero.
	assign rd_issue  = (state_q == ST_READ) && (rd_cnt_q < RCW'(WINDOW));
	assign ram_raddr = AW'(ch_idx_q) * AW'(WINDOW) + AW'(rd_cnt_q[IW-1:0]);
	assign rd_ok     = full_q[ch_idx_q] || (rd_cnt_q[IW-1:0] < ptr_q[ch_idx_q]);
	assign ins_val   = rd_ok_s1 ? ram_rdata : '0;

	mtmf_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DEPTH)
	) u_window_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(samples.sample),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Insertion sorter: each slot keeps its value, takes the new one, or takes its
	// lower neighbor, so the array stays ascending. Empty slots hold all ones.
	for (genvar g = 0; g < WINDOW; g++) begin : g_sort
		assign le[g] = sorted_q[g] <= ins_val;
		if (g == 0) begin : g_first
			assign sort_nxt[g] = le[g] ? sorted_q[g] : ins_val;
		end else begin : g_rest
			assign sort_nxt[g] = le[g] ? sorted_q[g] :
				(le[g-1] ? ins_val : sorted_q[g-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < WINDOW; i++) begin
				sorted_q[i] <= '1;
			end
		end else if (ins_s1) begin
			sorted_q <= sort_nxt;
		end
	end

	// Accumulation over the kept positions.
	assign pos_in    = !pos_q[PW-1] && (pos_q < WIN_S);
	assign last_kept = kept_cnt_q == KCW'(KEPT - 1);
	assign sum_nxt   = sum_q + (pos_in ? SW'(sorted_q[pos_q[IW-1:0]]) : SW'(0));

	// The quotient is the product shifted right by RSH; it always fits in one sample.
	assign prod = PRW'(sum_q) * PRW'(RECIP_M);

	assign out_free = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rd_cnt_q      <= '0;
			ins_s1        <= 1'b0;
			rd_ok_s1      <= 1'b0;
			kept_cnt_q    <= '0;
			pos_q         <= '0;
			sum_q         <= '0;
			quo_q         <= '0;
			ch_q          <= '0;
			ch_idx_q      <= '0;
			out_valid_q   <= 1'b0;
			out_channel_q <= '0;
			filtered_q    <= '0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				ptr_q[c]  <= '0;
				full_q[c] <= 1'b0;
			end
		end else begin
			ins_s1   <= rd_issue;
			rd_ok_s1 <= rd_ok;
			// The output register fills from the final state and empties when taken.
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ch_q     <= samples.channel;
						ch_idx_q <= in_idx;
						rd_cnt_q <= '0;
						if (ch_ok) begin
							if (ptr_q[in_idx] == IW'(WINDOW - 1)) begin
								ptr_q[in_idx]  <= '0;
								full_q[in_idx] <= 1'b1;
							end else begin
								ptr_q[in_idx] <= ptr_q[in_idx] + 1'b1;
							end
							state_q <= ST_READ;
						end else begin
							quo_q   <= '0;
							state_q <= ST_FIN;
						end
					end
				end
				ST_READ: begin
					if (rd_cnt_q == RCW'(WINDOW)) begin
						// The last read word is sorted in at this edge.
						kept_cnt_q <= '0;
						pos_q      <= START_S;
						sum_q      <= '0;
						state_q    <= ST_SUM;
					end else begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
				end
				ST_SUM: begin
					sum_q      <= sum_nxt;
					pos_q      <= pos_q + 1'b1;
					kept_cnt_q <= kept_cnt_q + 1'b1;
					if (last_kept) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					quo_q   <= prod[RSH +: SAMPLE_W];
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_channel_q <= ch_q;
						filtered_q    <= quo_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign results.valid       = out_valid_q;
	assign results.out_channel = out_channel_q;
	assign results.filtered    = filtered_q;

	// Once a beat is taken the block is busy in the next cycle.
	`MTMF_ASSERT_NEXT(a_busy_after_accept, accept, !samples.ready)
	// The divide state is always followed by the final state.
	`MTMF_ASSERT_NEXT(a_div_single, state_q == ST_DIV, state_q == ST_FIN)
	// The sorter has drained before the kept values are summed.
	`MTMF_ASSERT_NOW(a_sort_drained, state_q == ST_SUM, !ins_s1)
	// Sorter updates only happen while the window is being read.
	`MTMF_ASSERT_NOW(a_ins_in_read, ins_s1, state_q == ST_READ)
	// A waiting result stays valid and unchanged until it is taken.
	`MTMF_ASSERT_NEXT(a_result_held, results.valid && !results.ready, results.valid && $stable(results.filtered))

endmodule
